// ----- hdl/cdc_pkg.sv -----
// Shared types, constants and lookup functions for the civil date / day count converter.
// No dependencies; imported by cdc_front, cdc_split and civil_date_day_count_converter.
`timescale 1ns / 1ps
`default_nettype none

package cdc_pkg;

  // Opcodes
  localparam logic [1:0] OP_ENCODE = 2'd0;
  localparam logic [1:0] OP_DECODE = 2'd1;
  localparam logic [1:0] OP_OFFSET = 2'd2;

  // Field widths
  localparam int COUNT_W  = 22;
  localparam int DAY_W    = 5;
  localparam int MONTH_W  = 4;
  localparam int YEAR_W   = 14;
  localparam int OFFSET_W = 23;
  localparam int WDAY_W   = 3;

  // Port widths
  localparam int IN_TDATA_W  = 72;
  localparam int IN_TUSER_W  = 3;
  localparam int OUT_TDATA_W = 48;

  // Pipeline depths
  localparam int FRONT_STAGES = 2;
  localparam int SPLIT_STAGES = 8;

  // Internal widths
  localparam int Z_W   = COUNT_W + 1;
  localparam int ERA_W = 5;
  localparam int DOE_W = 18;
  localparam int YOE_W = 9;
  localparam int DOY_W = 9;
  localparam int MP_W  = 4;

  // Calendar constants
  localparam logic [COUNT_W-1:0] LAST_DAY_COUNT = 22'd2932896;
  localparam logic [YEAR_W-1:0]  YEAR_MIN       = 14'd1970;
  localparam logic [YEAR_W-1:0]  YEAR_MAX       = 14'd9999;
  localparam logic [MONTH_W-1:0] MONTH_JAN      = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB      = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC      = 4'd12;
  localparam logic [COUNT_W-1:0] ENC_BIAS       = 22'd478;
  localparam logic [Z_W-1:0]     EPOCH_SHIFT    = 23'd719468;
  localparam logic [Z_W-1:0]     WEEKDAY_BIAS   = 23'd4;
  localparam logic [DOE_W-1:0]   LAST_ERA_DAY   = 18'd146096;

  // Reciprocal multipliers: floor(x / D) == (x * K) >> SH over the used range
  localparam int ERA_SH = 40;
  localparam logic [63:0] ERA_K64 = ((64'd1 << ERA_SH) + 64'd146096) / 64'd146097;
  localparam int ERA_KW = $clog2(ERA_K64 + 64'd1);
  localparam logic [ERA_KW-1:0] ERA_K = ERA_K64[ERA_KW-1:0];
  localparam int ERA_PW = Z_W + ERA_KW;

  localparam int Q7_SH = 26;
  localparam int Q7_QW = 21;
  localparam logic [63:0] Q7_K64 = ((64'd1 << Q7_SH) + 64'd6) / 64'd7;
  localparam int Q7_KW = $clog2(Q7_K64 + 64'd1);
  localparam logic [Q7_KW-1:0] Q7_K = Q7_K64[Q7_KW-1:0];
  localparam int Q7_PW = Z_W + Q7_KW;

  localparam int Q100_SH = 21;
  localparam int Q100_QW = 8;
  localparam logic [63:0] Q100_K64 = ((64'd1 << Q100_SH) + 64'd99) / 64'd100;
  localparam int Q100_KW = $clog2(Q100_K64 + 64'd1);
  localparam logic [Q100_KW-1:0] Q100_K = Q100_K64[Q100_KW-1:0];
  localparam int Q100_PW = YEAR_W + Q100_KW;

  localparam int Q1460_SH = 29;
  localparam int Q1460_QW = 7;
  localparam logic [63:0] Q1460_K64 = ((64'd1 << Q1460_SH) + 64'd1459) / 64'd1460;
  localparam int Q1460_KW = $clog2(Q1460_K64 + 64'd1);
  localparam logic [Q1460_KW-1:0] Q1460_K = Q1460_K64[Q1460_KW-1:0];
  localparam int Q1460_PW = DOE_W + Q1460_KW;

  localparam int Q36524_SH = 34;
  localparam int Q36524_QW = 3;
  localparam logic [63:0] Q36524_K64 = ((64'd1 << Q36524_SH) + 64'd36523) / 64'd36524;
  localparam int Q36524_KW = $clog2(Q36524_K64 + 64'd1);
  localparam logic [Q36524_KW-1:0] Q36524_K = Q36524_K64[Q36524_KW-1:0];
  localparam int Q36524_PW = DOE_W + Q36524_KW;

  localparam int Q365_SH = 27;
  localparam logic [63:0] Q365_K64 = ((64'd1 << Q365_SH) + 64'd364) / 64'd365;
  localparam int Q365_KW = $clog2(Q365_K64 + 64'd1);
  localparam logic [Q365_KW-1:0] Q365_K = Q365_K64[Q365_KW-1:0];
  localparam int Q365_PW = DOE_W + Q365_KW;

  localparam int X153_W = 11;
  localparam int Q153_SH = 19;
  localparam logic [63:0] Q153_K64 = ((64'd1 << Q153_SH) + 64'd152) / 64'd153;
  localparam int Q153_KW = $clog2(Q153_K64 + 64'd1);
  localparam logic [Q153_KW-1:0] Q153_K = Q153_K64[Q153_KW-1:0];
  localparam int Q153_PW = X153_W + Q153_KW;

  typedef struct packed {
    logic [1:0]          op;
    logic [DAY_W-1:0]    day;
    logic [MONTH_W-1:0]  month;
    logic [YEAR_W-1:0]   year;
    logic [COUNT_W-1:0]  count;
    logic                count_ok;
    logic [OFFSET_W-1:0] offset;
  } cdc_req_t;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic               ok;
  } cdc_word_t;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic               ok;
    logic [DAY_W-1:0]   day;
    logic [MONTH_W-1:0] month;
    logic [YEAR_W-1:0]  year;
    logic [WDAY_W-1:0]  weekday;
  } cdc_date_t;

  // Length of a month in a common year; zero for a month number out of range
  function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m);
    logic [DAY_W-1:0] len;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

  // Days of a common year before the first of month m
  function automatic logic [8:0] days_before(input logic [MONTH_W-1:0] m);
    logic [8:0] n;
    unique case (m)
      4'd2:    n = 9'd31;
      4'd3:    n = 9'd59;
      4'd4:    n = 9'd90;
      4'd5:    n = 9'd120;
      4'd6:    n = 9'd151;
      4'd7:    n = 9'd181;
      4'd8:    n = 9'd212;
      4'd9:    n = 9'd243;
      4'd10:   n = 9'd273;
      4'd11:   n = 9'd304;
      4'd12:   n = 9'd334;
      default: n = 9'd0;
    endcase
    return n;
  endfunction

  // Days from March 1 to the first of March-based month mp
  function automatic logic [DOY_W-1:0] march_days(input logic [MP_W-1:0] mp);
    logic [DOY_W-1:0] n;
    unique case (mp)
      4'd1:    n = 9'd31;
      4'd2:    n = 9'd61;
      4'd3:    n = 9'd92;
      4'd4:    n = 9'd122;
      4'd5:    n = 9'd153;
      4'd6:    n = 9'd184;
      4'd7:    n = 9'd214;
      4'd8:    n = 9'd245;
      4'd9:    n = 9'd275;
      4'd10:   n = 9'd306;
      4'd11:   n = 9'd337;
      default: n = 9'd0;
    endcase
    return n;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/civil_date_day_count_converter.sv -----
// Throughput: one word per cycle unless out_tready holds back a full pipeline; every stage
// holds its own valid bit, so bubbles close up and in_tready stays high while any stage
// is empty, even when out_tready is low.
// Stages: 2 in the encode / offset front end, 8 in the count-to-date breakdown.
// Reset: rst_n is synchronous, active low, and clears only the stage valid bits.
// Depends on cdc_pkg, cdc_front and cdc_split.
`timescale 1ns / 1ps
`default_nettype none

module civil_date_day_count_converter
  import cdc_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  // in_day[4:0], in_month[8:5], in_year[22:9], in_count[44:23], offset_days[67:45], zeros
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  // opcode[1:0], in_count_ok[2]
  input  wire logic [IN_TUSER_W-1:0]  in_tuser,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  // out_count[21:0], out_day[26:22], out_month[30:27], out_year[44:31], out_weekday[47:45]
  output logic [OUT_TDATA_W-1:0]      out_tdata,
  // out_ok
  output logic                        out_tuser
);

  cdc_req_t  req;
  cdc_word_t word;
  cdc_date_t date;
  logic      word_valid;
  logic      word_ready;

  always_comb begin
    req.op       = in_tuser[1:0];
    req.count_ok = in_tuser[2];
    req.day      = in_tdata[4:0];
    req.month    = in_tdata[8:5];
    req.year     = in_tdata[22:9];
    req.count    = in_tdata[44:23];
    req.offset   = in_tdata[67:45];
  end

  cdc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_tvalid),
    .up_ready (in_tready),
    .up_req   (req),
    .dn_valid (word_valid),
    .dn_ready (word_ready),
    .dn_word  (word)
  );

  cdc_split u_split (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (word_valid),
    .up_ready (word_ready),
    .up_word  (word),
    .dn_valid (out_tvalid),
    .dn_ready (out_tready),
    .dn_date  (date)
  );

  assign out_tdata = {date.weekday, date.year, date.month, date.day, date.count};
  assign out_tuser = date.ok;

`ifndef SYNTHESIS
  a_full_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (out_tvalid && !out_tready))
    else $error("input blocked while the pipeline has an empty stage");

  a_invalid_pattern: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> ((out_tdata[21:0] == '0) && (out_tdata[26:22] == '0) &&
      (out_tdata[30:27] == MONTH_JAN) && (out_tdata[44:31] == '0) &&
      (out_tdata[47:45] == '0)))
    else $error("invalid result word carries nonzero fields");

  a_valid_date: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> ((out_tdata[21:0] <= LAST_DAY_COUNT) &&
      (out_tdata[26:22] != '0) && (out_tdata[30:27] >= MONTH_JAN) &&
      (out_tdata[30:27] <= MONTH_DEC) && (out_tdata[44:31] >= YEAR_MIN) &&
      (out_tdata[44:31] <= YEAR_MAX) && (out_tdata[47:45] <= 3'd6)))
    else $error("valid result word holds a field out of range");
`endif

endmodule

`default_nettype wire

// ----- hdl/cdc_front.sv -----
// Front end: date check and encode, offset add and range check, two register stages.
// Depends on cdc_pkg; yields one day count word with its valid flag per request.
`timescale 1ns / 1ps
`default_nettype none

module cdc_front
  import cdc_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      up_valid,
  output logic           up_ready,
  input  wire cdc_req_t  up_req,
  output logic           dn_valid,
  input  wire logic      dn_ready,
  output cdc_word_t      dn_word
);

  logic [FRONT_STAGES-1:0] v_r;
  logic [FRONT_STAGES-1:0] ld;

  always_comb begin
    ld[FRONT_STAGES-1] = !v_r[FRONT_STAGES-1] || dn_ready;
    for (int k = FRONT_STAGES - 2; k >= 0; k--) begin
      ld[k] = !v_r[k] || ld[k+1];
    end
  end

  assign up_ready = ld[0];
  assign dn_valid = v_r[FRONT_STAGES-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (ld[0]) begin
        v_r[0] <= up_valid;
      end
      for (int k = 1; k < FRONT_STAGES; k++) begin
        if (ld[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  // Stage 1: year quotients, year days, range flags, decode and offset words
  logic [YEAR_W-1:0]  ym1_nxt;
  logic [YEAR_W-1:0]  yd;
  logic [Q100_PW-1:0] qy_prod;
  logic [Q100_PW-1:0] qym1_prod;
  logic [Z_W-1:0]     ydays_full;
  logic               cnt_ok;
  logic [COUNT_W+1:0] sum;
  logic               sum_ok;
  logic               date_ok_nxt;
  cdc_word_t          alt_nxt;

  logic [1:0]          op_r;
  logic [DAY_W-1:0]    day_r;
  logic [MONTH_W-1:0]  month_r;
  logic [YEAR_W-1:0]   year_r;
  logic [YEAR_W-1:0]   ym1_r;
  logic [Q100_QW-1:0]  qy_r;
  logic [Q100_QW-1:0]  qym1_r;
  logic [COUNT_W-1:0]  ydays_r;
  logic                date_ok_r;
  cdc_word_t           alt_r;

  always_comb begin
    ym1_nxt    = up_req.year - 14'd1;
    yd         = up_req.year - YEAR_MIN;
    qy_prod    = Q100_PW'(up_req.year) * Q100_PW'(Q100_K);
    qym1_prod  = Q100_PW'(ym1_nxt) * Q100_PW'(Q100_K);
    ydays_full = Z_W'(yd) * Z_W'(9'd365);
    cnt_ok     = up_req.count_ok && (up_req.count <= LAST_DAY_COUNT);
    sum        = {2'b00, up_req.count} + {up_req.offset[OFFSET_W-1], up_req.offset};
    sum_ok     = !sum[COUNT_W+1] && (sum[COUNT_W:0] <= {1'b0, LAST_DAY_COUNT});
    date_ok_nxt = (up_req.year >= YEAR_MIN) && (up_req.year <= YEAR_MAX) &&
                  (up_req.month >= MONTH_JAN) && (up_req.month <= MONTH_DEC) &&
                  (up_req.day != '0);
    unique case (up_req.op)
      OP_DECODE: begin
        alt_nxt.count = up_req.count;
        alt_nxt.ok    = cnt_ok;
      end
      OP_OFFSET: begin
        alt_nxt.count = sum[COUNT_W-1:0];
        alt_nxt.ok    = cnt_ok && sum_ok;
      end
      default: begin
        alt_nxt.count = '0;
        alt_nxt.ok    = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      op_r      <= up_req.op;
      day_r     <= up_req.day;
      month_r   <= up_req.month;
      year_r    <= up_req.year;
      ym1_r     <= ym1_nxt;
      qy_r      <= qy_prod[Q100_SH +: Q100_QW];
      qym1_r    <= qym1_prod[Q100_SH +: Q100_QW];
      ydays_r   <= ydays_full[COUNT_W-1:0];
      date_ok_r <= date_ok_nxt;
      alt_r     <= alt_nxt;
    end
  end

  // Stage 2: leap year, day bound, encoded count, select by opcode
  logic [YEAR_W:0]    qy100;
  logic [YEAR_W-1:0]  rem100;
  logic               leap;
  logic [DAY_W-1:0]   mlen;
  logic               late;
  logic [COUNT_W-1:0] enc;
  logic               enc_ok;
  cdc_word_t          word_nxt;
  cdc_word_t          word_r;

  always_comb begin
    qy100  = (YEAR_W+1)'(qy_r) * (YEAR_W+1)'(7'd100);
    rem100 = year_r - qy100[YEAR_W-1:0];
    leap   = (year_r[1:0] == 2'd0) && ((rem100 != '0) || (qy_r[1:0] == 2'd0));
    mlen   = month_days(month_r) + DAY_W'(leap && (month_r == MONTH_FEB));
    late   = leap && (month_r > MONTH_FEB);
    enc    = ydays_r + COUNT_W'(ym1_r[YEAR_W-1:2]) - COUNT_W'(qym1_r)
           + COUNT_W'(qym1_r[Q100_QW-1:2]) + COUNT_W'(days_before(month_r))
           + COUNT_W'(late) + COUNT_W'(day_r) - ENC_BIAS;
    enc_ok = date_ok_r && (day_r <= mlen) && (enc <= LAST_DAY_COUNT);
    if (op_r == OP_ENCODE) begin
      word_nxt.count = enc;
      word_nxt.ok    = enc_ok;
    end else begin
      word_nxt = alt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      word_r <= word_nxt;
    end
  end

  assign dn_word = word_r;

endmodule

`default_nettype wire

// ----- hdl/cdc_split.sv -----
// Count to date pipeline: era, day of era, year of era, day of year, month and day, and weekday.
// Depends on cdc_pkg; eight register stages, the last one is the result register.
`timescale 1ns / 1ps
`default_nettype none

module cdc_split
  import cdc_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      up_valid,
  output logic           up_ready,
  input  wire cdc_word_t up_word,
  output logic           dn_valid,
  input  wire logic      dn_ready,
  output cdc_date_t      dn_date
);

  typedef struct packed {
    logic [ERA_W-1:0]   era;
    logic [WDAY_W-1:0]  wd;
    logic [COUNT_W-1:0] count;
    logic               ok;
  } carry_t;

  logic [SPLIT_STAGES-1:0] v_r;
  logic [SPLIT_STAGES-1:0] ld;

  always_comb begin
    ld[SPLIT_STAGES-1] = !v_r[SPLIT_STAGES-1] || dn_ready;
    for (int k = SPLIT_STAGES - 2; k >= 0; k--) begin
      ld[k] = !v_r[k] || ld[k+1];
    end
  end

  assign up_ready = ld[0];
  assign dn_valid = v_r[SPLIT_STAGES-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (ld[0]) begin
        v_r[0] <= up_valid;
      end
      for (int k = 1; k < SPLIT_STAGES; k++) begin
        if (ld[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  // Stage 1: shift to March-based epoch, era and weekday quotients
  logic [Z_W-1:0]    z;
  logic [Z_W-1:0]    w;
  logic [ERA_PW-1:0] era_prod;
  logic [Q7_PW-1:0]  q7_prod;
  logic [ERA_W-1:0]  s1_era_r;
  logic [Z_W-1:0]    s1_z_r;
  logic [Z_W-1:0]    s1_w_r;
  logic [Q7_QW-1:0]  s1_q7_r;
  cdc_word_t         s1_word_r;

  always_comb begin
    z        = Z_W'(up_word.count) + EPOCH_SHIFT;
    w        = Z_W'(up_word.count) + WEEKDAY_BIAS;
    era_prod = ERA_PW'(z) * ERA_PW'(ERA_K);
    q7_prod  = Q7_PW'(w) * Q7_PW'(Q7_K);
  end

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      s1_era_r  <= era_prod[ERA_SH +: ERA_W];
      s1_z_r    <= z;
      s1_w_r    <= w;
      s1_q7_r   <= q7_prod[Q7_SH +: Q7_QW];
      s1_word_r <= up_word;
    end
  end

  // Stage 2: day of era, weekday remainder
  logic [Z_W-1:0]   era_days;
  logic [Z_W-1:0]   doe_full;
  logic [Z_W:0]     q7x7;
  logic [Z_W-1:0]   wd_full;
  logic [DOE_W-1:0] s2_doe_r;
  carry_t           s2_c_r;

  always_comb begin
    era_days = Z_W'(s1_era_r) * Z_W'(18'd146097);
    doe_full = s1_z_r - era_days;
    q7x7     = (Z_W+1)'(s1_q7_r) * (Z_W+1)'(3'd7);
    wd_full  = s1_w_r - q7x7[Z_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      s2_doe_r     <= doe_full[DOE_W-1:0];
      s2_c_r.era   <= s1_era_r;
      s2_c_r.wd    <= wd_full[WDAY_W-1:0];
      s2_c_r.count <= s1_word_r.count;
      s2_c_r.ok    <= s1_word_r.ok;
    end
  end

  // Stage 3: leap corrections of the day of era
  logic [Q1460_PW-1:0]  q1460_prod;
  logic [Q36524_PW-1:0] q36524_prod;
  logic [Q1460_QW-1:0]  s3_q1460_r;
  logic [Q36524_QW-1:0] s3_q36524_r;
  logic [DOE_W-1:0]     s3_doe_r;
  carry_t               s3_c_r;

  always_comb begin
    q1460_prod  = Q1460_PW'(s2_doe_r) * Q1460_PW'(Q1460_K);
    q36524_prod = Q36524_PW'(s2_doe_r) * Q36524_PW'(Q36524_K);
  end

  always_ff @(posedge clk) begin
    if (ld[2]) begin
      s3_q1460_r  <= q1460_prod[Q1460_SH +: Q1460_QW];
      s3_q36524_r <= q36524_prod[Q36524_SH +: Q36524_QW];
      s3_doe_r    <= s2_doe_r;
      s3_c_r      <= s2_c_r;
    end
  end

  // Stage 4: corrected day of era
  logic [DOE_W-1:0] t_nxt;
  logic [DOE_W-1:0] s4_t_r;
  logic [DOE_W-1:0] s4_doe_r;
  carry_t           s4_c_r;

  always_comb begin
    t_nxt = s3_doe_r - DOE_W'(s3_q1460_r) + DOE_W'(s3_q36524_r)
          - DOE_W'(s3_doe_r == LAST_ERA_DAY);
  end

  always_ff @(posedge clk) begin
    if (ld[3]) begin
      s4_t_r   <= t_nxt;
      s4_doe_r <= s3_doe_r;
      s4_c_r   <= s3_c_r;
    end
  end

  // Stage 5: year of era
  logic [Q365_PW-1:0] yoe_prod;
  logic [YOE_W-1:0]   s5_yoe_r;
  logic [DOE_W-1:0]   s5_doe_r;
  carry_t             s5_c_r;

  always_comb begin
    yoe_prod = Q365_PW'(s4_t_r) * Q365_PW'(Q365_K);
  end

  always_ff @(posedge clk) begin
    if (ld[4]) begin
      s5_yoe_r <= yoe_prod[Q365_SH +: YOE_W];
      s5_doe_r <= s4_doe_r;
      s5_c_r   <= s4_c_r;
    end
  end

  // Stage 6: day of March-based year
  logic [1:0]       c100;
  logic [DOE_W-1:0] ystart;
  logic [DOE_W-1:0] doy_full;
  logic [DOY_W-1:0] s6_doy_r;
  logic [YOE_W-1:0] s6_yoe_r;
  carry_t           s6_c_r;

  always_comb begin
    c100     = 2'(s5_yoe_r >= 9'd100) + 2'(s5_yoe_r >= 9'd200) + 2'(s5_yoe_r >= 9'd300);
    ystart   = DOE_W'(s5_yoe_r) * DOE_W'(9'd365) + DOE_W'(s5_yoe_r[YOE_W-1:2])
             - DOE_W'(c100);
    doy_full = s5_doe_r - ystart;
  end

  always_ff @(posedge clk) begin
    if (ld[5]) begin
      s6_doy_r <= doy_full[DOY_W-1:0];
      s6_yoe_r <= s5_yoe_r;
      s6_c_r   <= s5_c_r;
    end
  end

  // Stage 7: March-based month
  logic [X153_W-1:0]  x153;
  logic [Q153_PW-1:0] mp_prod;
  logic [MP_W-1:0]    s7_mp_r;
  logic [DOY_W-1:0]   s7_doy_r;
  logic [YOE_W-1:0]   s7_yoe_r;
  carry_t             s7_c_r;

  always_comb begin
    x153    = {s6_doy_r, 2'b00} + {2'b00, s6_doy_r} + 11'd2;
    mp_prod = Q153_PW'(x153) * Q153_PW'(Q153_K);
  end

  always_ff @(posedge clk) begin
    if (ld[6]) begin
      s7_mp_r  <= mp_prod[Q153_SH +: MP_W];
      s7_doy_r <= s6_doy_r;
      s7_yoe_r <= s6_yoe_r;
      s7_c_r   <= s6_c_r;
    end
  end

  // Stage 8: calendar fields, invalid words forced to the fixed pattern
  logic [DOY_W-1:0]   dd_full;
  logic [MONTH_W-1:0] mm;
  logic [YEAR_W-1:0]  era400;
  logic [YEAR_W-1:0]  yy;
  cdc_date_t          date_nxt;
  cdc_date_t          date_r;

  always_comb begin
    dd_full = s7_doy_r - march_days(s7_mp_r) + 9'd1;
    if (s7_mp_r < 4'd10) begin
      mm = s7_mp_r + 4'd3;
    end else begin
      mm = s7_mp_r - 4'd9;
    end
    era400 = YEAR_W'(s7_c_r.era) * YEAR_W'(9'd400);
    yy     = YEAR_W'(s7_yoe_r) + era400 + YEAR_W'(mm <= MONTH_FEB);
    if (s7_c_r.ok) begin
      date_nxt.count   = s7_c_r.count;
      date_nxt.ok      = 1'b1;
      date_nxt.day     = dd_full[DAY_W-1:0];
      date_nxt.month   = mm;
      date_nxt.year    = yy;
      date_nxt.weekday = s7_c_r.wd;
    end else begin
      date_nxt.count   = '0;
      date_nxt.ok      = 1'b0;
      date_nxt.day     = '0;
      date_nxt.month   = MONTH_JAN;
      date_nxt.year    = '0;
      date_nxt.weekday = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (ld[7]) begin
      date_r <= date_nxt;
    end
  end

  assign dn_date = date_r;

endmodule

`default_nettype wire
